### rtl/core/wpm_pkg.sv
// wpm_pkg: beat types, item kinds and wildcard byte codes for the
// wildcard pattern matcher. No dependencies.
`timescale 1ns / 1ps

package wpm_pkg;

   typedef enum logic [1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_TEXT   = 2'd2,
      KIND_END    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  symbol;
   } req_type;

   typedef struct packed {
      logic matched;
      logic pattern_overflow;
   } rsp_type;

   // Broadcast to every cell in the chain.
   typedef struct packed {
      logic        step;      // text byte accepted
      logic        restart;   // live set restarts at position zero
      logic [7:0]  symbol;
   } cell_ctrl_type;

   localparam logic [7:0] STAR_BYTE  = 8'h2A;
   localparam logic [7:0] QMARK_BYTE = 8'h3F;

endpackage

### rtl/core/wpm_cell.sv
// wpm_cell: one pattern position. Holds its pattern byte and live bit,
// passes the match shift and star closure ripple to the next cell. Uses wpm_pkg.
`timescale 1ns / 1ps

module wpm_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  wpm_pkg::cell_ctrl_type ctrl,
   input  logic                   init_live,
   input  logic                   write_here,
   input  logic                   active_now,
   input  logic                   active_next,
   input  logic                   seed_in,
   input  logic                   carry_in,
   output logic                   hit_out,
   output logic                   carry_out,
   output logic                   live_out
);

   logic [7:0] pat_ff;
   logic       live_ff;
   logic       live_in;
   logic       star_now;
   logic       star_next;
   logic       raw;
   logic       closed;

   assign star_now  = active_now & (pat_ff == wpm_pkg::STAR_BYTE);
   assign star_next = active_next &
                      (write_here ? (ctrl.symbol == wpm_pkg::STAR_BYTE)
                                  : (pat_ff == wpm_pkg::STAR_BYTE));

   assign hit_out = ctrl.step & active_now & live_ff & ~star_now &
                    ((pat_ff == wpm_pkg::QMARK_BYTE) | (pat_ff == ctrl.symbol));

   assign raw       = (ctrl.step & live_ff & star_now) | seed_in;
   assign closed    = raw | carry_in;
   assign carry_out = closed & star_next;
   assign live_out  = live_ff;

   always_comb begin
      live_in = live_ff;
      if (ctrl.step | ctrl.restart) begin
         live_in = closed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= init_live;
      end else begin
         live_ff <= live_in;
      end
   end

   always_ff @(posedge clock) begin
      if (write_here) begin
         pat_ff <= ctrl.symbol;
      end
   end

endmodule

### rtl/core/wildcard_pattern_matcher.sv
// wildcard_pattern_matcher: glob matcher ('*', '?') built as a chain of
// wpm_cell positions plus the end position. Uses wpm_pkg and wpm_cell.
// One beat of any kind per cycle unless stalled. The end-of-text result
// is registered and offered on rsp the cycle after its beat is taken.
// The critical path is the star closure ripple through all MAX_PATTERN cells.
// Reset: empty pattern, overflow clear, only position zero live, rsp empty.
`timescale 1ns / 1ps

module wildcard_pattern_matcher #(
   parameter int MAX_PATTERN = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  wpm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output wpm_pkg::rsp_type rsp_data
);

   localparam int LW = $clog2(MAX_PATTERN + 1);

   logic [LW-1:0]          len_ff;
   logic [LW-1:0]          len_in;
   logic                   overflow_ff;
   logic                   overflow_in;
   logic                   live_top_ff;
   logic                   live_top_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   wpm_pkg::rsp_type       rsp_data_ff;
   wpm_pkg::rsp_type       rsp_data_in;

   logic                   req_acc;
   logic                   is_clear;
   logic                   is_append;
   logic                   is_text;
   logic                   is_end;
   logic                   full;
   logic                   matched;
   wpm_pkg::cell_ctrl_type ctrl;

   logic [MAX_PATTERN-1:0] write_here;
   logic [MAX_PATTERN-1:0] active_now;
   logic [MAX_PATTERN-1:0] active_next;
   logic [MAX_PATTERN-1:0] seed;
   logic [MAX_PATTERN-1:0] hit;
   logic [MAX_PATTERN:0]   carry;
   logic [MAX_PATTERN:0]   live_bits;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_acc   = req_valid & ~req_stall;

   always_comb begin
      is_clear  = 1'b0;
      is_append = 1'b0;
      is_text   = 1'b0;
      is_end    = 1'b0;
      case (req_data.kind)
         wpm_pkg::KIND_CLEAR:  is_clear  = req_acc;
         wpm_pkg::KIND_APPEND: is_append = req_acc;
         wpm_pkg::KIND_TEXT:   is_text   = req_acc;
         wpm_pkg::KIND_END:    is_end    = req_acc;
         default:              is_clear  = 1'b0;
      endcase
   end

   assign full = (len_ff == LW'(MAX_PATTERN));

   always_comb begin
      len_in      = len_ff;
      overflow_in = overflow_ff;
      if (is_clear) begin
         len_in      = '0;
         overflow_in = 1'b0;
      end else if (is_append) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            len_in = len_ff + LW'(1);
         end
      end
   end

   assign ctrl.step    = is_text;
   assign ctrl.restart = is_clear | is_append | is_end;
   assign ctrl.symbol  = req_data.symbol;

   assign carry[0] = 1'b0;

   for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
      assign write_here[i]  = is_append & ~full & (len_ff == LW'(i));
      assign active_now[i]  = (LW'(i) < len_ff);
      assign active_next[i] = (LW'(i) < len_in);
      if (i == 0) begin : g_first
         assign seed[i] = ctrl.restart;
      end else begin : g_rest
         assign seed[i] = hit[i-1];
      end

      wpm_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .init_live   ((i == 0) ? 1'b1 : 1'b0),
         .write_here  (write_here[i]),
         .active_now  (active_now[i]),
         .active_next (active_next[i]),
         .seed_in     (seed[i]),
         .carry_in    (carry[i]),
         .hit_out     (hit[i]),
         .carry_out   (carry[i+1]),
         .live_out    (live_bits[i])
      );
   end

   assign live_bits[MAX_PATTERN] = live_top_ff;

   always_comb begin
      live_top_in = live_top_ff;
      if (ctrl.step | ctrl.restart) begin
         live_top_in = (ctrl.step & hit[MAX_PATTERN-1]) | carry[MAX_PATTERN];
      end
   end

   assign matched = live_bits[len_ff] & ~overflow_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff & ~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (is_end) begin
         rsp_valid_in                 = 1'b1;
         rsp_data_in.matched          = matched;
         rsp_data_in.pattern_overflow = overflow_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         overflow_ff  <= 1'b0;
         live_top_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         len_ff       <= len_in;
         overflow_ff  <= overflow_in;
         live_top_ff  <= live_top_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### sim/wildcard_pattern_matcher_tb.sv
// wildcard_pattern_matcher_tb: self-checking bench for the glob matcher. It streams
// pattern and text beats with random gaps and stalls and checks every result beat.
// Depends on wpm_pkg and wildcard_pattern_matcher.
`timescale 1ns / 1ps

module wildcard_pattern_matcher_tb;

   localparam int MAX_PAT = 32;
   localparam int RANDOM_BEATS = 1800;
   localparam int CHOKE_CYCLES = 250;
   localparam logic [7:0] LETTER_A = "a";
   localparam logic [MAX_PAT:0] LIVE_START = {{MAX_PAT{1'b0}}, 1'b1};

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   wpm_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   wpm_pkg::rsp_type rsp_data;

   wildcard_pattern_matcher #(.MAX_PATTERN(MAX_PAT)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // Glob predictor state.
   logic [7:0]       pat_mem [MAX_PAT];
   int unsigned      pat_len;
   logic [MAX_PAT:0] live;
   logic             pat_ovf;
   wpm_pkg::rsp_type verdicts_due [$];

   // Stimulus plan and the pattern as the generator sees it.
   wpm_pkg::req_type beat_plan [$];
   logic [7:0]       gen_pat [$];
   int               planned_total;

   int  beats_taken = 0;
   int  verdicts_seen = 0;
   int  error_count = 0;
   logic req_fire = 1'b0;
   logic rsp_fire = 1'b0;

   int  req_sent = 0;
   int  req_gap = 0;
   bit  req_burst = 1'b0;
   int  rsp_wait = 0;
   int  choke_left = 0;
   bit  rsp_burst = 1'b0;

   function automatic logic [MAX_PAT:0] close_stars(input logic [MAX_PAT:0] s);
      for (int i = 0; i < pat_len; i++)
         if (s[i] && pat_mem[i] == wpm_pkg::STAR_BYTE) s[i + 1] = 1'b1;
      return s;
   endfunction

   function automatic void glob_reset();
      pat_len = 0;
      pat_ovf = 1'b0;
      live = LIVE_START;
   endfunction

   function automatic void track_beat(input wpm_pkg::req_type b);
      logic [MAX_PAT:0] nxt;
      wpm_pkg::rsp_type r;
      case (b.kind)
         wpm_pkg::KIND_CLEAR: begin
            pat_len = 0;
            pat_ovf = 1'b0;
         end
         wpm_pkg::KIND_APPEND: begin
            if (pat_len < MAX_PAT) begin
               pat_mem[pat_len] = b.symbol;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         wpm_pkg::KIND_TEXT: begin
            nxt = '0;
            for (int i = 0; i < pat_len; i++)
               if (live[i]) begin
                  if (pat_mem[i] == wpm_pkg::STAR_BYTE) nxt[i] = 1'b1;
                  else if (pat_mem[i] == wpm_pkg::QMARK_BYTE || pat_mem[i] == b.symbol)
                     nxt[i + 1] = 1'b1;
               end
            live = close_stars(nxt);
         end
         default: begin
            r.matched = live[pat_len] && !pat_ovf;
            r.pattern_overflow = pat_ovf;
            verdicts_due.push_back(r);
         end
      endcase
      if (b.kind != wpm_pkg::KIND_TEXT) live = close_stars(LIVE_START);
   endfunction

   // ---------------- stimulus helpers ----------------
   function automatic void add_beat(input wpm_pkg::kind_type k, input logic [7:0] s);
      wpm_pkg::req_type b;
      b.kind = k;
      b.symbol = s;
      beat_plan.push_back(b);
      if (k == wpm_pkg::KIND_CLEAR) gen_pat.delete();
      else if (k == wpm_pkg::KIND_APPEND && gen_pat.size() < MAX_PAT) gen_pat.push_back(s);
   endfunction

   function automatic logic [7:0] pick_letter();
      return LETTER_A + 8'($urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] pattern_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 22) return wpm_pkg::STAR_BYTE;
      if (r < 37) return wpm_pkg::QMARK_BYTE;
      if (r < 90) return pick_letter();
      return 8'($urandom);
   endfunction

   function automatic void load_pattern(input int len);
      if ($urandom_range(0, 9) != 0) add_beat(wpm_pkg::KIND_CLEAR, 8'($urandom));
      repeat (len) add_beat(wpm_pkg::KIND_APPEND, pattern_char());
   endfunction

   // Text built to fit the pattern, optionally garbled by one edit.
   function automatic void add_text(input bit garble);
      logic [7:0] txt [$];
      int n;
      foreach (gen_pat[i]) begin
         if (gen_pat[i] == wpm_pkg::STAR_BYTE) begin
            n = $urandom_range(0, 3);
            repeat (n) txt.push_back(pick_letter());
         end else if (gen_pat[i] == wpm_pkg::QMARK_BYTE) begin
            txt.push_back(8'($urandom));
         end else begin
            txt.push_back(gen_pat[i]);
         end
      end
      if (garble) begin
         case ($urandom_range(0, 2))
            0: if (txt.size() > 0) txt.delete($urandom_range(0, txt.size() - 1));
            1: txt.insert($urandom_range(0, txt.size()), pick_letter());
            default: if (txt.size() > 0) txt[$urandom_range(0, txt.size() - 1)] = 8'($urandom);
         endcase
      end
      foreach (txt[i]) add_beat(wpm_pkg::KIND_TEXT, txt[i]);
      add_beat(wpm_pkg::KIND_END, 8'($urandom));
   endfunction

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("wildcard_pattern_matcher_tb NOT OK");
      $finish;
   end

   // ---------------- plan, reset, end of run ----------------
   initial begin
      int sel;
      int plen;
      // empty pattern vs empty and non-empty text
      add_beat(wpm_pkg::KIND_END, 8'h00);
      add_beat(wpm_pkg::KIND_TEXT, LETTER_A);
      add_beat(wpm_pkg::KIND_END, 8'hFF);
      // lone star, empty text and extreme bytes
      add_beat(wpm_pkg::KIND_APPEND, wpm_pkg::STAR_BYTE);
      add_beat(wpm_pkg::KIND_END, 8'h00);
      add_beat(wpm_pkg::KIND_TEXT, 8'hFF);
      add_beat(wpm_pkg::KIND_TEXT, 8'h00);
      add_beat(wpm_pkg::KIND_END, 8'hFF);
      // question mark takes a star byte in the text
      add_beat(wpm_pkg::KIND_CLEAR, 8'hFF);
      add_beat(wpm_pkg::KIND_APPEND, wpm_pkg::QMARK_BYTE);
      add_beat(wpm_pkg::KIND_TEXT, wpm_pkg::STAR_BYTE);
      add_beat(wpm_pkg::KIND_END, 8'h00);
      // append in mid-text drops the text in progress
      add_beat(wpm_pkg::KIND_CLEAR, 8'h00);
      add_beat(wpm_pkg::KIND_APPEND, 8'hFF);
      add_beat(wpm_pkg::KIND_TEXT, 8'hFF);
      add_beat(wpm_pkg::KIND_APPEND, 8'h00);
      add_beat(wpm_pkg::KIND_TEXT, 8'hFF);
      add_beat(wpm_pkg::KIND_TEXT, 8'h00);
      add_beat(wpm_pkg::KIND_END, 8'h00);
      add_beat(wpm_pkg::KIND_TEXT, 8'hFF);
      add_beat(wpm_pkg::KIND_END, 8'hFF);

      while (beat_plan.size() < RANDOM_BEATS) begin
         sel = $urandom_range(0, 99);
         if (sel < 85) begin
            plen = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
            load_pattern(plen);
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 9) == 0) begin
                  repeat ($urandom_range(1, 3)) add_beat(wpm_pkg::KIND_TEXT, pick_letter());
                  add_beat(wpm_pkg::KIND_APPEND, pattern_char());
               end
               add_text($urandom_range(0, 4) == 0);
            end
         end else begin
            repeat ($urandom_range(1, 6))
               add_beat(wpm_pkg::kind_type'($urandom_range(0, 3)), 8'($urandom));
         end
      end
      planned_total = beat_plan.size();

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (beats_taken != planned_total || verdicts_due.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("wildcard_pattern_matcher_tb OK");
      end else begin
         $display("wildcard_pattern_matcher_tb NOT OK");
      end
      $finish;
   end

   // ---------------- request driver ----------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
      end else if (!req_valid || req_fire) begin
         if (req_fire) begin
            req_sent++;
            if (req_sent % 100 == 0) req_burst = ($urandom_range(0, 2) == 0);
            req_gap = req_burst ? 0 : $urandom_range(0, 3);
         end
         if (req_gap > 0 || beat_plan.size() == 0) begin
            if (req_gap > 0) req_gap--;
            req_valid <= 1'b0;
         end else begin
            req_data <= beat_plan.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // ---------------- result receiver ----------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait = 0;
         choke_left = 0;
      end else begin
         if (rsp_fire) begin
            if (verdicts_seen % 50 == 0) rsp_burst = ($urandom_range(0, 2) == 0);
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 3);
            // long hold-off so the block backs up into req
            if (verdicts_seen == 20 || verdicts_seen == 120) choke_left = CHOKE_CYCLES;
         end
         if (choke_left > 0) begin
            choke_left--;
            rsp_stall <= 1'b1;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- monitor and checker ----------------
   always @(posedge clock) begin
      wpm_pkg::rsp_type due;
      if (reset) begin
         req_fire <= 1'b0;
         rsp_fire <= 1'b0;
         glob_reset();
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            verdicts_seen++;
            if (verdicts_due.size() == 0) begin
               $error("rsp beat with no result pending: matched %0b overflow %0b",
                      rsp_data.matched, rsp_data.pattern_overflow);
               error_count++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_data.matched !== due.matched) begin
                  $error("matched: expected %0b, got %0b", due.matched, rsp_data.matched);
                  error_count++;
               end
               if (rsp_data.pattern_overflow !== due.pattern_overflow) begin
                  $error("pattern_overflow: expected %0b, got %0b",
                         due.pattern_overflow, rsp_data.pattern_overflow);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            track_beat(req_data);
            beats_taken++;
         end
      end
   end

endmodule

### wildcard_pattern_matcher.f
rtl/core/wpm_pkg.sv
rtl/core/wpm_cell.sv
rtl/core/wildcard_pattern_matcher.sv
sim/wildcard_pattern_matcher_tb.sv
